// File: hdl/circular_service_queue_macros.svh
// Assertion macros used by the circular service queue RTL.
`ifndef CIRCULAR_SERVICE_QUEUE_MACROS_SVH
`define CIRCULAR_SERVICE_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define CSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csq assertion failed");
`define CSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csq assertion failed");
`else
`define CSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/csq_pkg.sv
// Types and constants of the circular service queue.
`timescale 1ns / 1ps
package csq_pkg;

  localparam int ID_W   = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_DROP   = 3'd1,
    K_ROTATE = 3'd2,
    K_REMOVE = 3'd3,
    K_CLEAR  = 3'd4,
    K_LIST   = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   entry_id;
    logic [LEN_W-1:0]  queue_length;
    logic              last_of_run;
  } res_t;

endpackage

// File: hdl/csq_chan_if.sv
// Request and result channel interfaces of the circular service queue.
`timescale 1ns / 1ps
interface csq_in_if;
  import csq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   item_id;
  modport source (output valid, output kind, output item_id, input ready);
  modport sink (input valid, input kind, input item_id, output ready);
endinterface

interface csq_out_if;
  import csq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   entry_id;
  logic [LEN_W-1:0]  queue_length;
  logic              last_of_run;
  modport source (output valid, output status, output entry_id, output queue_length,
                  output last_of_run, input ready);
  modport sink (input valid, input status, input entry_id, input queue_length,
                input last_of_run, output ready);
endinterface

// File: hdl/csq_ring_mem.sv
// Ring storage of queue ids: one write port, one registered read port.
`timescale 1ns / 1ps
module csq_ring_mem #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [csq_pkg::ID_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [csq_pkg::ID_W-1:0] rd_data
);
  import csq_pkg::*;

  logic [ID_W-1:0] slot_mem_r [DEPTH];
  logic [ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/csq_ctrl.sv
// Request sequencer: decodes each item and walks the ring memory.
`timescale 1ns / 1ps
`include "circular_service_queue_macros.svh"
module csq_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [csq_pkg::KIND_W-1:0] in_kind,
  input  logic [csq_pkg::ID_W-1:0]   in_item_id,
  output logic                       in_ready,
  input  logic                       out_free,
  output logic                       push,
  output csq_pkg::res_t              res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [csq_pkg::ID_W-1:0]   mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [csq_pkg::ID_W-1:0]   mem_rdata
);
  import csq_pkg::*;

  state_t          state_r, state_nxt;
  kind_t           kind_r, kind_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  status_t         stat_r, stat_nxt;
  logic [ID_W-1:0] entry_r, entry_nxt;

  logic [CW-1:0]   pos_inc;
  logic [CW-1:0]   pos_dec;
  logic [31:0]     fill_wide;
  logic [LEN_W-1:0] fill_len;
  logic            list_last;

  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign pos_inc   = pos_r + CW'(1);
  assign pos_dec   = pos_r - CW'(1);
  assign fill_wide = 32'(fill_r);
  assign fill_len  = fill_wide[LEN_W-1:0];
  assign list_last = (pos_inc == fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
    kind_r  <= kind_nxt;
    id_r    <= id_nxt;
    pos_r   <= pos_nxt;
    stat_r  <= stat_nxt;
    entry_r <= entry_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    stat_nxt  = stat_r;
    entry_nxt = entry_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    res.status       = stat_r;
    res.entry_id     = entry_r;
    res.queue_length = fill_len;
    res.last_of_run  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = ring_at(head_r, fill_r[AW-1:0]);
    mem_wdata = id_r;
    mem_re    = 1'b0;
    mem_raddr = ring_at(head_r, pos_inc[AW-1:0]);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          id_nxt    = in_item_id;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        entry_nxt = '0;
        state_nxt = S_RESP;
        case (kind_r)
          K_APPEND: begin
            if (fill_r == CW'(DEPTH)) begin
              stat_nxt = STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + CW'(1);
              stat_nxt = STAT_OK;
            end
          end
          K_DROP, K_ROTATE, K_REMOVE, K_LIST: begin
            if (fill_r == '0) begin
              stat_nxt = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
              pos_nxt   = '0;
              if (kind_r == K_REMOVE) begin
                state_nxt = S_SRCH;
              end else if (kind_r == K_LIST) begin
                state_nxt = S_LIST;
              end else begin
                state_nxt = S_POP;
              end
            end
          end
          K_CLEAR: begin
            fill_nxt = '0;
            head_nxt = '0;
            stat_nxt = STAT_OK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        stat_nxt  = STAT_OK;
        entry_nxt = mem_rdata;
        head_nxt  = ring_at(head_r, AW'(1));
        if (kind_r == K_DROP) begin
          fill_nxt = fill_r - CW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
        state_nxt = S_RESP;
      end
      S_SRCH: begin
        if (mem_rdata == id_r) begin
          if (pos_inc == fill_r) begin
            fill_nxt  = fill_r - CW'(1);
            stat_nxt  = STAT_OK;
            entry_nxt = id_r;
            state_nxt = S_RESP;
          end else begin
            mem_re    = 1'b1;
            pos_nxt   = pos_inc;
            state_nxt = S_SHIFT;
          end
        end else if (pos_inc == fill_r) begin
          stat_nxt  = STAT_NOTFOUND;
          entry_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          mem_re  = 1'b1;
          pos_nxt = pos_inc;
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ring_at(head_r, pos_dec[AW-1:0]);
        mem_wdata = mem_rdata;
        if (pos_inc == fill_r) begin
          fill_nxt  = fill_r - CW'(1);
          stat_nxt  = STAT_OK;
          entry_nxt = id_r;
          state_nxt = S_RESP;
        end else begin
          mem_re  = 1'b1;
          pos_nxt = pos_inc;
        end
      end
      S_LIST: begin
        res.status      = STAT_OK;
        res.entry_id    = mem_rdata;
        res.last_of_run = list_last;
        if (out_free) begin
          push = 1'b1;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            pos_nxt = pos_inc;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `CSQ_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(DEPTH))
  `CSQ_ASSERT_IMPLY(a_no_rw_clash, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
  `CSQ_ASSERT_IMPLY(a_push_free, clk, rst_n, push, out_free)
  `CSQ_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)

endmodule

// File: hdl/circular_service_queue.sv
// Top level of the circular service queue: sequencer, ring memory and result register.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, item_id
//   out_ch   out  valid/ready    status, entry_id, queue_length, last_of_run
//
// Append and clear pass accept, execute, respond; drop and rotate add a pop step; remove
// searches, then shifts each later entry down a slot; list emits one result per entry,
// or an empty status. Every entry read passes through the single registered read port of
// the ring memory. Reset clears the fill level and head; the ring contents need no
// clearing. A finished result waits in the output register while the next item is taken;
// the final step of an item and each list step hold while the register is full and unread.
`timescale 1ns / 1ps
module circular_service_queue #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  csq_in_if.sink       in_ch,
  csq_out_if.source    out_ch
);
  import csq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r, out_res_nxt;
  logic            out_free;
  logic            push;
  res_t            res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ID_W-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ID_W-1:0] mem_rdata;

  assign out_free = !out_valid_r || out_ch.ready;

  csq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_kind    (in_ch.kind),
    .in_item_id (in_ch.item_id),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .push       (push),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  csq_ring_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.entry_id     = out_res_r.entry_id;
  assign out_ch.queue_length = out_res_r.queue_length;
  assign out_ch.last_of_run  = out_res_r.last_of_run;

endmodule
